// ===== hdl/bitmap_area_resampler_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and masked during rst.
// ---------------------------------------------------------------------------
`ifndef BITMAP_AREA_RESAMPLER_MACROS_SVH
`define BITMAP_AREA_RESAMPLER_MACROS_SVH

// Same-cycle implication.
`define BAR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BAR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bar_pkg.sv =====
// ---------------------------------------------------------------------------
// bar_pkg
// Types, codes and field widths shared by the bitmap area resampler.
// ---------------------------------------------------------------------------
package bar_pkg;

  // default sizes
  localparam int DEF_MAX_FLAGS  = 16384;
  localparam int DEF_MAX_PIXELS = 4096;

  // fixed field widths
  localparam int FLAG_COUNT_W  = 15;
  localparam int PIXEL_COUNT_W = 13;
  localparam int FLAG_INDEX_W  = 14;
  localparam int PIXEL_INDEX_W = 12;
  localparam int COVERAGE_W    = 16;
  localparam int CFG_DATA_W    = 15;
  localparam int CFG_INDEX_W   = 1;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_FLAG_COUNT  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_COUNT = 1'b1;

  // classified operation carried through the queue
  typedef enum logic [1:0] {
    OP_WRITE,
    OP_RANGE,
    OP_EMPTY,
    OP_QUERY
  } op_t;

  // back end sequencer
  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_DIV1,
    B_WALK,
    B_SCALE,
    B_DIV2,
    B_OUT
  } bstate_t;

endpackage

// ===== hdl/bar_front.sv =====
// ---------------------------------------------------------------------------
// bar_front
// Takes request beats, classifies them and holds one entry for the queue.
// ---------------------------------------------------------------------------
module bar_front import bar_pkg::*; #(
  parameter int MAX_FLAGS  = DEF_MAX_FLAGS,
  parameter int MAX_PIXELS = DEF_MAX_PIXELS,
  localparam int AW = (MAX_FLAGS > 1) ? $clog2(MAX_FLAGS) : 1,
  localparam int NW = $clog2(MAX_FLAGS + 1),
  localparam int WW = $clog2(MAX_PIXELS + 1),
  localparam int XW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_stall,
  input  logic                     command,
  input  logic [FLAG_INDEX_W-1:0]  flag_index,
  input  logic                     flag_value,
  input  logic [PIXEL_INDEX_W-1:0] pixel_index,
  input  logic [NW-1:0]            n,
  input  logic [WW-1:0]            w,
  output logic                     push,
  output op_t                      push_op,
  output logic [AW-1:0]            push_addr,
  output logic                     push_value,
  output logic [XW-1:0]            push_pixel,
  input  logic                     q_full
);

  logic ent_valid;
  logic accept;
  logic keep;
  logic in_store;
  op_t  op_class;

  assign req_stall = ent_valid && q_full;
  assign push      = ent_valid && !q_full;
  assign accept    = req_valid && !req_stall;

  // writes beyond the store are dropped here
  assign in_store = 32'(flag_index) < 32'(MAX_FLAGS);
  assign keep     = (command == CMD_QUERY) || in_store;

  always_comb begin
    if (command == CMD_WRITE) begin
      op_class = OP_WRITE;
    end else if (32'(pixel_index) >= 32'(w)) begin
      op_class = OP_RANGE;
    end else if (n == '0) begin
      op_class = OP_EMPTY;
    end else begin
      op_class = OP_QUERY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= 1'b0;
    end else begin
      if (push) begin
        ent_valid <= 1'b0;
      end
      if (accept) begin
        ent_valid <= keep;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      push_op    <= op_class;
      push_addr  <= AW'(flag_index);
      push_value <= flag_value;
      push_pixel <= XW'(pixel_index);
    end
  end

endmodule

// ===== hdl/bar_fifo.sv =====
// ---------------------------------------------------------------------------
// bar_fifo
// Short queue of classified operations between front and back.
// ---------------------------------------------------------------------------
`include "bitmap_area_resampler_macros.svh"

module bar_fifo import bar_pkg::*; #(
  parameter int AW = 14,
  parameter int XW = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  op_t           in_op,
  input  logic [AW-1:0] in_addr,
  input  logic          in_value,
  input  logic [XW-1:0] in_pixel,
  output logic          full,
  input  logic          pop,
  output logic          nempty,
  output op_t           out_op,
  output logic [AW-1:0] out_addr,
  output logic          out_value,
  output logic [XW-1:0] out_pixel
);

  localparam int PTRW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  op_t           q_op    [QUEUE_DEPTH];
  logic [AW-1:0] q_addr  [QUEUE_DEPTH];
  logic          q_value [QUEUE_DEPTH];
  logic [XW-1:0] q_pixel [QUEUE_DEPTH];

  logic [PTRW-1:0] wr_ptr;
  logic [PTRW-1:0] rd_ptr;
  logic [CNTW-1:0] count;

  assign full      = count == CNTW'(QUEUE_DEPTH);
  assign nempty    = count != '0;
  assign out_op    = q_op[rd_ptr];
  assign out_addr  = q_addr[rd_ptr];
  assign out_value = q_value[rd_ptr];
  assign out_pixel = q_pixel[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTRW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTRW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_op[wr_ptr]    <= in_op;
      q_addr[wr_ptr]  <= in_addr;
      q_value[wr_ptr] <= in_value;
      q_pixel[wr_ptr] <= in_pixel;
    end
  end

  `BAR_ASSERT_NOW(a_no_push_full, push, !full, "queue pushed while full")
  `BAR_ASSERT_NOW(a_no_pop_empty, pop, nempty, "queue popped while empty")

endmodule

// ===== hdl/bar_div.sv =====
// ---------------------------------------------------------------------------
// bar_div
// Restoring divider, one quotient bit per cycle; done pulses when finished.
// ---------------------------------------------------------------------------
module bar_div import bar_pkg::*; #(
  parameter int DW = 32,
  parameter int VW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quo,
  output logic [VW-1:0] rem
);

  localparam int CW = $clog2(DW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [VW-1:0] d;
  logic [VW:0]   trial;
  logic          ge;
  logic [VW-1:0] rem_next;

  assign trial    = {rem, quo[DW-1]};
  assign ge       = trial >= {1'b0, d};
  assign rem_next = ge ? VW'(trial - {1'b0, d}) : VW'(trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      d   <= divisor;
    end else if (busy) begin
      quo <= {quo[DW-2:0], ge};
      rem <= rem_next;
    end
  end

endmodule

// ===== hdl/bar_back.sv =====
// ---------------------------------------------------------------------------
// bar_back
// Runs queued flag writes, out-of-range and empty results, and coverage
// queries by a flag walk between two passes of a shared serial divider.
// ---------------------------------------------------------------------------
`include "bitmap_area_resampler_macros.svh"

module bar_back import bar_pkg::*; #(
  parameter int MAX_FLAGS  = DEF_MAX_FLAGS,
  parameter int MAX_PIXELS = DEF_MAX_PIXELS,
  localparam int AW = (MAX_FLAGS > 1) ? $clog2(MAX_FLAGS) : 1,
  localparam int NW = $clog2(MAX_FLAGS + 1),
  localparam int WW = $clog2(MAX_PIXELS + 1),
  localparam int XW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [NW-1:0]         n,
  input  logic [WW-1:0]         w,
  input  logic                  q_nempty,
  input  op_t                   q_op,
  input  logic [AW-1:0]         q_addr,
  input  logic                  q_value,
  input  logic [XW-1:0]         q_pixel,
  output logic                  pop,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output logic [COVERAGE_W-1:0] coverage,
  output logic                  out_of_range
);

  localparam int PW = NW + WW;
  localparam int DW = (PW > NW + COVERAGE_W) ? PW : NW + COVERAGE_W;
  localparam int VW = (NW > WW) ? NW : WW;

  bstate_t state, state_next;

  logic mem [MAX_FLAGS];

  logic [XW-1:0] x;
  logic [PW-1:0] p0, p1, fs, fe, lo, hi;
  logic [PW-1:0] product;
  logic [NW-1:0] i;
  logic [NW-1:0] sum;
  logic          pend_valid;
  logic [WW-1:0] pend_ov;
  logic [WW-1:0] ov;
  logic          rd_bit;
  logic          rd_en;
  logic          wr_en;
  logic          walk_go;
  logic          out_free;
  logic          load_out;
  logic [COVERAGE_W-1:0] out_cov;
  logic          out_oor;

  logic          div_start;
  logic [DW-1:0] div_dividend;
  logic [VW-1:0] div_divisor;
  logic          div_done;
  logic [DW-1:0] div_quo;
  logic [VW-1:0] div_rem;

  // flag span and its overlap with the pixel span
  assign product = PW'(x) * PW'(n);
  assign fe      = fs + PW'(w);
  assign lo      = (fs > p0) ? fs : p0;
  assign hi      = (fe < p1) ? fe : p1;
  assign ov      = WW'(hi - lo);
  assign walk_go = (i < n) && (fs < p1);

  assign out_free = !rsp_valid || !rsp_stall;
  assign wr_en    = pop && (q_op == OP_WRITE);

  assign div_dividend = (state == B_MUL) ? DW'(product)
                      : (DW'(sum) << COVERAGE_W) - DW'(sum);
  assign div_divisor  = (state == B_MUL) ? VW'(w) : VW'(n);

  bar_div #(
    .DW(DW),
    .VW(VW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_out   = 1'b0;
    out_cov    = '0;
    out_oor    = 1'b0;
    div_start  = 1'b0;
    rd_en      = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (q_nempty) begin
          unique case (q_op)
            OP_WRITE: begin
              pop = 1'b1;
            end
            OP_RANGE, OP_EMPTY: begin
              if (out_free) begin
                pop      = 1'b1;
                load_out = 1'b1;
                out_oor  = q_op == OP_RANGE;
              end
            end
            OP_QUERY: begin
              pop        = 1'b1;
              state_next = B_MUL;
            end
          endcase
        end
      end
      B_MUL: begin
        div_start  = 1'b1;
        state_next = B_DIV1;
      end
      B_DIV1: begin
        if (div_done) begin
          state_next = B_WALK;
        end
      end
      B_WALK: begin
        if (walk_go) begin
          rd_en = 1'b1;
        end else begin
          state_next = B_SCALE;
        end
      end
      B_SCALE: begin
        div_start  = 1'b1;
        state_next = B_DIV2;
      end
      B_DIV2: begin
        if (div_done) begin
          state_next = B_OUT;
        end
      end
      B_OUT: begin
        if (out_free) begin
          load_out   = 1'b1;
          out_cov    = div_quo[COVERAGE_W-1:0];
          state_next = B_IDLE;
        end
      end
    endcase
  end

  // flag store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[q_addr] <= q_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_bit <= mem[i[AW-1:0]];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (load_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (state == B_WALK) begin
        pend_valid <= walk_go;
      end else begin
        pend_valid <= 1'b0;
      end
    end
  end

  // query datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      x <= q_pixel;
    end
    if (state == B_MUL) begin
      p0 <= product;
    end
    if (state == B_DIV1) begin
      p1 <= p0 + PW'(n);
      if (div_done) begin
        i   <= div_quo[NW-1:0];
        fs  <= p0 - PW'(div_rem);
        sum <= '0;
      end
    end
    if (state == B_WALK) begin
      // read data of the flag issued last cycle
      if (pend_valid && rd_bit) begin
        sum <= sum + NW'(pend_ov);
      end
      if (walk_go) begin
        pend_ov <= ov;
        i       <= i + 1'b1;
        fs      <= fe;
      end
    end
    if (load_out) begin
      coverage     <= out_cov;
      out_of_range <= out_oor;
    end
  end

  `BAR_ASSERT_NOW(a_sum_bound, state == B_WALK, sum <= n,
                  "overlap sum exceeds pixel length")
  `BAR_ASSERT_NOW(a_first_flag, (state == B_DIV1) && div_done, div_quo < DW'(n),
                  "first flag of pixel beyond flag count")
  `BAR_ASSERT_NOW(a_div_owner, div_done, (state == B_DIV1) || (state == B_DIV2),
                  "divider finished with no waiting step")
  `BAR_ASSERT_NEXT(a_out_loaded, load_out, rsp_valid,
                   "loaded result not shown")

endmodule

// ===== hdl/bitmap_area_resampler.sv =====
// ---------------------------------------------------------------------------
// bitmap_area_resampler
// Area-averaging resampler for a one-bit flag map, top level.
// ---------------------------------------------------------------------------
// Keeps up to MAX_FLAGS one-bit flags and answers, per output pixel, what
// fraction of it is covered by set flags, as floor(overlap*65535/N) with N
// the flag count and W the pixel count (pixel x spans [x*N,(x+1)*N), flag i
// spans [i*W,(i+1)*W)). A write beat stores one flag and gives no result; a
// query beat gives one result beat. Pixel indexes not below W give coverage
// 0 with out_of_range set; an empty map gives 0. Register values above the
// built sizes saturate. Flags read by a query must have been written first.
// Writes and trivial queries drain at one per cycle while the back end is
// idle, trivial ones only while the result register is free. A full query
// holds the back end through two shared-divider passes (first flag, then
// scaling) around a walk of each flag the pixel touches (roughly N/W + 2).
// The divider gives one quotient bit per cycle and is DW = max(NW + WW, NW
// + 16) bits wide for NW, WW the bit widths of MAX_FLAGS, MAX_PIXELS; DW
// is 31 at the default sizes. A two-entry queue lets the front keep taking
// beats while a query runs, and the result register holds a finished beat
// while the back end moves on. Registers must only be written while idle.
module bitmap_area_resampler import bar_pkg::*; #(
  parameter int MAX_FLAGS  = DEF_MAX_FLAGS,
  parameter int MAX_PIXELS = DEF_MAX_PIXELS
) (
  input  logic                     clk,
  input  logic                     rst,
  // configuration
  input  logic                     cfg_we,
  input  logic [CFG_INDEX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  // request channel
  input  logic                     req_valid,
  output logic                     req_stall,
  input  logic                     command,
  input  logic [FLAG_INDEX_W-1:0]  flag_index,
  input  logic                     flag_value,
  input  logic [PIXEL_INDEX_W-1:0] pixel_index,
  // response channel
  output logic                     rsp_valid,
  input  logic                     rsp_stall,
  output logic [COVERAGE_W-1:0]    coverage,
  output logic                     out_of_range
);

  localparam int AW = (MAX_FLAGS > 1) ? $clog2(MAX_FLAGS) : 1;
  localparam int NW = $clog2(MAX_FLAGS + 1);
  localparam int WW = $clog2(MAX_PIXELS + 1);
  localparam int XW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

  // saturated register values
  logic [NW-1:0] n;
  logic [WW-1:0] w;

  // front to queue
  logic          push;
  op_t           push_op;
  logic [AW-1:0] push_addr;
  logic          push_value;
  logic [XW-1:0] push_pixel;
  logic          q_full;

  // queue to back
  logic          pop;
  logic          q_nempty;
  op_t           q_op;
  logic [AW-1:0] q_addr;
  logic          q_value;
  logic [XW-1:0] q_pixel;

  logic [FLAG_COUNT_W-1:0]  cfg_flags;
  logic [PIXEL_COUNT_W-1:0] cfg_pixels;

  assign cfg_flags  = cfg_data[FLAG_COUNT_W-1:0];
  assign cfg_pixels = cfg_data[PIXEL_COUNT_W-1:0];

  // register file, clipped to the built sizes on write
  always_ff @(posedge clk) begin
    if (rst) begin
      n <= '0;
      w <= WW'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FLAG_COUNT: begin
          if (32'(cfg_flags) > 32'(MAX_FLAGS)) begin
            n <= NW'(MAX_FLAGS);
          end else begin
            n <= NW'(cfg_flags);
          end
        end
        REG_PIXEL_COUNT: begin
          if (32'(cfg_pixels) > 32'(MAX_PIXELS)) begin
            w <= WW'(MAX_PIXELS);
          end else begin
            w <= WW'(cfg_pixels);
          end
        end
      endcase
    end
  end

  bar_front #(
    .MAX_FLAGS  (MAX_FLAGS),
    .MAX_PIXELS (MAX_PIXELS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .command     (command),
    .flag_index  (flag_index),
    .flag_value  (flag_value),
    .pixel_index (pixel_index),
    .n           (n),
    .w           (w),
    .push        (push),
    .push_op     (push_op),
    .push_addr   (push_addr),
    .push_value  (push_value),
    .push_pixel  (push_pixel),
    .q_full      (q_full)
  );

  bar_fifo #(
    .AW (AW),
    .XW (XW)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .in_op     (push_op),
    .in_addr   (push_addr),
    .in_value  (push_value),
    .in_pixel  (push_pixel),
    .full      (q_full),
    .pop       (pop),
    .nempty    (q_nempty),
    .out_op    (q_op),
    .out_addr  (q_addr),
    .out_value (q_value),
    .out_pixel (q_pixel)
  );

  bar_back #(
    .MAX_FLAGS  (MAX_FLAGS),
    .MAX_PIXELS (MAX_PIXELS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .n            (n),
    .w            (w),
    .q_nempty     (q_nempty),
    .q_op         (q_op),
    .q_addr       (q_addr),
    .q_value      (q_value),
    .q_pixel      (q_pixel),
    .pop          (pop),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .coverage     (coverage),
    .out_of_range (out_of_range)
  );

endmodule

// ===== verif/bitmap_area_resampler_monitor.sv =====
// ---------------------------------------------------------------------------
// bitmap_area_resampler_monitor
// Watches the configuration port and both channels of the resampler, keeps
// its own flag map and register copies, predicts the coverage of every query
// beat and checks each result beat against the oldest prediction.
// ---------------------------------------------------------------------------
module bitmap_area_resampler_monitor import bar_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_INDEX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic                     req_valid,
  input  logic                     req_stall,
  input  logic                     command,
  input  logic [FLAG_INDEX_W-1:0]  flag_index,
  input  logic                     flag_value,
  input  logic [PIXEL_INDEX_W-1:0] pixel_index,
  input  logic                     rsp_valid,
  input  logic                     rsp_stall,
  input  logic [COVERAGE_W-1:0]    coverage,
  input  logic                     out_of_range,
  output int                       outstanding,
  output int                       mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned FULL_SCALE = 65535;

  typedef struct packed {
    logic [COVERAGE_W-1:0] coverage;
    logic                  out_of_range;
  } coverage_beat_t;

  bit                       flag_map [DEF_MAX_FLAGS];
  logic [FLAG_COUNT_W-1:0]  flag_count_copy  = '0;
  logic [PIXEL_COUNT_W-1:0] pixel_count_copy = 1;
  coverage_beat_t           pending_coverage [$];
  int                       error_count = 0;

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    error_count++;
  endtask

  // Overlap of pixel x with the set flags, scaled so full cover is 65535.
  function automatic coverage_beat_t predict_coverage(logic [PIXEL_INDEX_W-1:0] px);
    longint unsigned n, w, x, p0, p1, first, last, sum, lo, hi, i;
    coverage_beat_t  beat;
    n = flag_count_copy;
    w = pixel_count_copy;
    x = px;
    if (n > DEF_MAX_FLAGS) n = DEF_MAX_FLAGS;
    if (w > DEF_MAX_PIXELS) w = DEF_MAX_PIXELS;
    beat.coverage     = '0;
    beat.out_of_range = 1'b0;
    if (x >= w) begin
      beat.out_of_range = 1'b1;
      return beat;
    end
    if (n == 0) return beat;
    p0    = x * n;
    p1    = p0 + n;
    first = p0 / w;
    last  = (p1 + w - 1) / w;
    if (last > n) last = n;
    sum = 0;
    for (i = first; i < last; i++) begin
      if (flag_map[i]) begin
        lo = (p0 > i * w) ? p0 : i * w;
        hi = (p1 < (i + 1) * w) ? p1 : (i + 1) * w;
        if (hi > lo) sum += hi - lo;
      end
    end
    beat.coverage = COVERAGE_W'((sum * FULL_SCALE) / n);
    return beat;
  endfunction

  always @(posedge clk) begin
    coverage_beat_t want;
    if (rst) begin
      flag_count_copy  = '0;
      pixel_count_copy = 1;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FLAG_COUNT:  flag_count_copy  = cfg_data[FLAG_COUNT_W-1:0];
          REG_PIXEL_COUNT: pixel_count_copy = cfg_data[PIXEL_COUNT_W-1:0];
          default: ;
        endcase
      end
      if (req_valid && !req_stall) begin
        if (command == CMD_WRITE) flag_map[flag_index] = flag_value;
        else pending_coverage.push_back(predict_coverage(pixel_index));
      end
      if (rsp_valid && !rsp_stall) begin
        if (pending_coverage.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing expected (coverage %0d)",
                                    coverage));
        end else begin
          want = pending_coverage.pop_front();
          if (coverage !== want.coverage)
            report_mismatch($sformatf("coverage got %0d expected %0d",
                                      coverage, want.coverage));
          if (out_of_range !== want.out_of_range)
            report_mismatch($sformatf("out_of_range got %b expected %b",
                                      out_of_range, want.out_of_range));
        end
      end
    end
    outstanding <= pending_coverage.size();
    mismatches  <= error_count;
  end

endmodule

// ===== verif/bitmap_area_resampler_test.sv =====
// ---------------------------------------------------------------------------
// bitmap_area_resampler_test
// Top of the resampler testbench: clock, reset, stimulus and verdict.
// ---------------------------------------------------------------------------
// A short directed run covers the reset settings, the empty map, pixels out
// of range, a zero pixel count, a saturated pixel count and the extreme flag
// positions. Randomised phases follow, each one programming both registers
// while the block is idle, then mixing in-range queries with noise queries
// and writes; ahead of each query any flag it touches that was never written
// is written first. Both sides idle at random; some phases run with no idling
// and one holds the result side off for a long stretch so the block backs
// up. Checking lives in the monitor.
// ---------------------------------------------------------------------------
module bitmap_area_resampler_test;
  import bar_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 80;        // wait for trailing writes to drain
  localparam int LONG_HOLD     = 300;       // result side hold-off
  localparam int LIMIT_CYCLES  = 2_000_000;
  localparam int TARGET_BEATS  = 750;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     cfg_we;
  logic [CFG_INDEX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;
  logic                     req_valid;
  logic                     req_stall;
  logic                     command;
  logic [FLAG_INDEX_W-1:0]  flag_index;
  logic                     flag_value;
  logic [PIXEL_INDEX_W-1:0] pixel_index;
  logic                     rsp_valid;
  logic                     rsp_stall;
  logic [COVERAGE_W-1:0]    coverage;
  logic                     out_of_range;

  int outstanding;
  int mismatches;

  // phase controls, written with NBAs so the response side sees them cleanly
  bit quiet_phase    = 1'b0;
  bit pressure_armed = 1'b0;

  // flags already written; a query must never touch one that is not
  bit flag_written [DEF_MAX_FLAGS];
  int cur_flags    = 0;   // effective N after saturation
  int cur_pixels   = 1;   // effective W after saturation
  int fill_density = 50;
  int sent_beats   = 0;
  int cycle_count  = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  bitmap_area_resampler u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .command      (command),
    .flag_index   (flag_index),
    .flag_value   (flag_value),
    .pixel_index  (pixel_index),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .coverage     (coverage),
    .out_of_range (out_of_range)
  );

  bitmap_area_resampler_monitor u_monitor (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .command      (command),
    .flag_index   (flag_index),
    .flag_value   (flag_value),
    .pixel_index  (pixel_index),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .coverage     (coverage),
    .out_of_range (out_of_range),
    .outstanding  (outstanding),
    .mismatches   (mismatches)
  );

  // Watchdog: a hung handshake ends the run here.
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Result side. Each accepted beat draws a short stall; once armed, a single
  // long hold-off is counted out here while the sender keeps offering.
  initial begin
    int wait_left;
    int long_left;
    bit pressure_taken;
    wait_left      = 0;
    long_left      = 0;
    pressure_taken = 1'b0;
    rsp_stall      = 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_valid && !rsp_stall) wait_left = quiet_phase ? 0 : $urandom_range(0, 5);
      if (pressure_armed && !pressure_taken) begin
        long_left      = LONG_HOLD;
        pressure_taken = 1'b1;
      end
      if (long_left > 0) begin
        long_left--;
        rsp_stall <= 1'b1;
      end else if (wait_left > 0) begin
        wait_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  function automatic logic draw_flag(int density);
    return $urandom_range(0, 99) < density;
  endfunction

  // One request beat. Valid stays high into the next beat when no gap is
  // drawn, so back-to-back beats never see valid dropped and raised.
  task automatic send_beat(logic cmd, logic [FLAG_INDEX_W-1:0] fidx, logic fval,
                           logic [PIXEL_INDEX_W-1:0] pidx);
    int gap;
    gap = quiet_phase ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid   <= 1'b1;
    command     <= cmd;
    flag_index  <= fidx;
    flag_value  <= fval;
    pixel_index <= pidx;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (cmd == CMD_WRITE) flag_written[fidx] = 1'b1;
    sent_beats++;
  endtask

  // unused fields carry noise so every bit toggles
  task automatic send_write(int idx, logic val);
    send_beat(CMD_WRITE, FLAG_INDEX_W'(idx), val, PIXEL_INDEX_W'($urandom_range(0, 4095)));
  endtask

  // Write every never-written flag that pixel px overlaps.
  task automatic fill_pixel(int px);
    longint first;
    longint last;
    longint j;
    if (px >= cur_pixels || cur_flags == 0) return;
    first = (longint'(px) * cur_flags) / cur_pixels;
    last  = (longint'(px + 1) * cur_flags + cur_pixels - 1) / cur_pixels;
    if (last > cur_flags) last = cur_flags;
    for (j = first; j < last; j++) begin
      if (!flag_written[j]) send_write(int'(j), draw_flag(fill_density));
    end
  endtask

  task automatic send_query(int px);
    fill_pixel(px);
    send_beat(CMD_QUERY, FLAG_INDEX_W'($urandom_range(0, 16383)), 1'($urandom_range(0, 1)),
              PIXEL_INDEX_W'(px));
  endtask

  // Drop valid, let every expected beat arrive, then let trailing writes
  // drain out of the queue.
  task automatic wait_idle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Both registers, only while idle; pixel_count carries noise above bit 12.
  task automatic program_registers(int n, int w);
    logic [1:0] pad;
    pad = $urandom_range(0, 3);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_FLAG_COUNT;
    cfg_data  <= CFG_DATA_W'(n);
    @(posedge clk);
    cfg_index <= REG_PIXEL_COUNT;
    cfg_data  <= {pad, PIXEL_COUNT_W'(w)};
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_flags  = (n % 32768 > DEF_MAX_FLAGS) ? DEF_MAX_FLAGS : n % 32768;
    cur_pixels = (w % 8192 > DEF_MAX_PIXELS) ? DEF_MAX_PIXELS : w % 8192;
  endtask

  // One setting: program, then a mix of well-formed queries, noise queries
  // and writes.
  task automatic run_phase(int n, int w, int density, int beats, bit no_idle,
                           bit with_pressure);
    int pick;
    int k;
    program_registers(n, w);
    quiet_phase <= no_idle;
    fill_density = density;
    if (with_pressure) pressure_armed <= 1'b1;
    for (k = 0; k < beats; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60 && cur_pixels > 0) send_query($urandom_range(0, cur_pixels - 1));
      else if (pick < 75) send_query($urandom_range(0, 4095));
      else if (pick < 88 && cur_flags > 0) send_write($urandom_range(0, cur_flags - 1),
                                                      draw_flag(density));
      else send_write($urandom_range(0, 16383), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int n;
    int w;
    int density;
    int sel;
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = REG_FLAG_COUNT;
    cfg_data    = '0;
    req_valid   = 1'b0;
    command     = CMD_WRITE;
    flag_index  = '0;
    flag_value  = 1'b0;
    pixel_index = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: empty map, one pixel
    send_query(0);
    send_query(4095);
    send_write(16383, 1'b1);
    send_write(0, 1'b1);
    send_write(16383, 1'b0);
    // one flag over one pixel: full cover, then cleared
    program_registers(1, 1);
    send_query(0);
    send_query(1);
    send_write(0, 1'b0);
    send_query(0);
    send_write(0, 1'b1);
    // zero pixel count: every pixel is out of range
    program_registers(2, 0);
    send_query(0);
    send_query(4095);
    // empty map with the largest pixel count
    program_registers(0, 4096);
    send_query(4095);
    send_query(0);
    send_write(1, 1'b1);
    send_write(2, 1'b0);
    // pixel count above the built size saturates; upsampled flags
    program_registers(3, 8191);
    send_query(4095);
    send_query(1365);
    send_query(0);

    // both registers saturated, dense map over the whole store
    run_phase(32767, 8191, 100, 20, 1'b0, 1'b0);
    run_phase(16384, 4096, 50, 20, 1'b0, 1'b0);
    // whole map into one pixel: long walks, so only a few beats
    run_phase(96, 1, 30, 3, 1'b0, 1'b0);
    run_phase(93, 7, 60, 5, 1'b0, 1'b0);
    // result side held off while queries keep coming
    run_phase(40, 13, 50, 60, 1'b0, 1'b1);
    // no idling on either side
    run_phase(100, 33, 70, 40, 1'b1, 1'b0);
    run_phase(0, 0, 50, 20, 1'b0, 1'b0);
    run_phase(0, 8191, 50, 20, 1'b0, 1'b0);
    run_phase(5, 4096, 50, 40, 1'b0, 1'b0);

    while (sent_beats < TARGET_BEATS) begin
      sel = $urandom_range(0, 9);
      n = (sel < 8) ? $urandom_range(1, 300) : $urandom_range(300, 16384);
      sel = $urandom_range(0, 9);
      if (sel < 5) w = $urandom_range(1, n);
      else if (sel < 8) w = $urandom_range(n, 4096);
      else if (sel < 9) w = $urandom_range(4096, 8191);
      else w = 0;
      // keep the walk per query short
      if (w > 0 && n / w > 8) w = n / 8 + 1;
      if ($urandom_range(0, 15) == 0) n = 0;
      sel = $urandom_range(0, 3);
      density = (sel == 0) ? 0 : (sel == 1) ? 100 : $urandom_range(0, 100);
      run_phase(n, w, density, $urandom_range(10, 20), $urandom_range(0, 5) == 0, 1'b0);
    end

    wait_idle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== bitmap_area_resampler.f =====
+incdir+hdl
hdl/bar_pkg.sv
hdl/bar_front.sv
hdl/bar_fifo.sv
hdl/bar_div.sv
hdl/bar_back.sv
hdl/bitmap_area_resampler.sv
verif/bitmap_area_resampler_monitor.sv
verif/bitmap_area_resampler_test.sv
